// ===== hdl/frp_pkg.sv =====
package frp_pkg;

    // Telnet command bytes.
    localparam logic [7:0] TN_IAC  = 8'd255;
    localparam logic [7:0] TN_DONT = 8'd254;
    localparam logic [7:0] TN_DO   = 8'd253;
    localparam logic [7:0] TN_WONT = 8'd252;
    localparam logic [7:0] TN_WILL = 8'd251;

    // Characters with a meaning in the reply text.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_RPAR  = 8'h29;

    // Reply codes.
    localparam logic [9:0] CODE_PASV = 10'd227;
    localparam logic [9:0] CODE_LOST = 10'd421;
    localparam logic [9:0] CODE_BYE  = 10'd221;

    // Default depth of the queue between the classifier and the parser.
    localparam int QUEUE_DEPTH = 4;

    // A classified request as it travels through the queue.
    typedef struct packed {
        logic       eos;
        logic       expect_close;
        logic [7:0] data;
        logic       is_digit;
        logic [3:0] digit_val;
        logic       is_iac;
        logic       is_lf;
        logic       is_term;
        logic       is_dash;
        logic       is_will_wont;
        logic       is_do_dont;
    } item_t;

    // One result as the parser produces it.
    typedef struct packed {
        logic       neg_send;
        logic       neg_verb;
        logic [7:0] neg_option;
        logic       pasv_valid;
        logic [7:0] pasv_byte;
        logic       pasv_last;
        logic       reply_done;
        logic [7:0] reply_lead;
        logic [9:0] reply_code;
        logic       lost_peer;
    } result_t;

endpackage

// ===== hdl/frp_front.sv =====
module frp_front
(
    input  logic [7:0]    rx_byte,
    input  logic          end_of_stream,
    input  logic          expect_close,
    output frp_pkg::item_t item
);

    // Classify the byte on its own, with no state, so that the parser only
    // has to look at flags.
    always_comb
    begin
        item.eos          = end_of_stream;
        item.expect_close = expect_close;
        item.data         = rx_byte;
        item.is_digit     = (rx_byte >= frp_pkg::CH_ZERO) && (rx_byte <= frp_pkg::CH_NINE);
        item.digit_val    = rx_byte[3:0];
        item.is_iac       = (rx_byte == frp_pkg::TN_IAC);
        item.is_lf        = (rx_byte == frp_pkg::CH_LF);
        item.is_term      = (rx_byte == frp_pkg::CH_CR) || (rx_byte == frp_pkg::CH_RPAR);
        item.is_dash      = (rx_byte == frp_pkg::CH_DASH);
        item.is_will_wont = (rx_byte == frp_pkg::TN_WILL) || (rx_byte == frp_pkg::TN_WONT);
        item.is_do_dont   = (rx_byte == frp_pkg::TN_DO) || (rx_byte == frp_pkg::TN_DONT);
    end

endmodule

// ===== hdl/frp_queue.sv =====
module frp_queue
#(
    parameter int Depth = frp_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  frp_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output frp_pkg::item_t head
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    frp_pkg::item_t          slots_reg [Depth];
    logic [PtrW-1:0]         wr_ptr_reg;
    logic [PtrW-1:0]         wr_ptr_next;
    logic [PtrW-1:0]         rd_ptr_reg;
    logic [PtrW-1:0]         rd_ptr_next;
    logic [CntW-1:0]         count_reg;
    logic [CntW-1:0]         count_next;
    logic                    do_push;
    logic                    do_pop;

    assign full      = (count_reg == FullCnt);
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Pointer and fill count update, wrapping at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset: the fill count says what is valid.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/frp_back.sv =====
module frp_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             avail,
    input  frp_pkg::item_t   item,
    output logic             take,
    output logic             result_valid,
    input  logic             result_stall,
    output frp_pkg::result_t result
);

    typedef enum logic [1:0]
    {
        TN_NONE   = 2'd0,
        TN_AFTER  = 2'd1,
        TN_OPTION = 2'd2
    } tn_state_t;

    typedef enum logic [1:0]
    {
        PV_IDLE   = 2'd0,
        PV_SAW    = 2'd1,
        PV_STREAM = 2'd2,
        PV_DONE   = 2'd3
    } pv_state_t;

    tn_state_t        tn_reg;
    tn_state_t        tn_next;
    pv_state_t        pv_reg;
    pv_state_t        pv_next;
    logic             wont_reg;
    logic             wont_next;
    logic [2:0]       line_pos_reg;
    logic [2:0]       line_pos_next;
    logic [9:0]       line_code_reg;
    logic [9:0]       line_code_next;
    logic [9:0]       first_code_reg;
    logic [9:0]       first_code_next;
    logic             cont_reg;
    logic             cont_next;
    logic [7:0]       lead_reg;
    logic [7:0]       lead_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    frp_pkg::result_t out_reg;
    frp_pkg::result_t out_next;
    logic [9:0]       code_times_ten;
    logic [2:0]       pos_inc;

    // A new request is taken whenever the output register is free or emptying.
    assign take         = avail && (!out_valid_reg || !result_stall);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign code_times_ten = {line_code_reg[6:0], 3'b000} + {line_code_reg[8:0], 1'b0};
    assign pos_inc        = (line_pos_reg < 3'd5) ? line_pos_reg + 3'd1 : 3'd5;

    // Per-request state update and result.
    always_comb
    begin
        tn_next         = tn_reg;
        pv_next         = pv_reg;
        wont_next       = wont_reg;
        line_pos_next   = line_pos_reg;
        line_code_next  = line_code_reg;
        first_code_next = first_code_reg;
        cont_next       = cont_reg;
        lead_next       = lead_reg;
        out_next        = '0;
        out_valid_next  = out_valid_reg && result_stall;

        if (take)
        begin
            out_valid_next = 1'b1;
            if (item.eos)
            begin
                // Connection closed: report and return to reset.
                out_next.reply_done = 1'b1;
                if (item.expect_close)
                begin
                    out_next.reply_lead = frp_pkg::CH_ZERO;
                    out_next.reply_code = frp_pkg::CODE_BYE;
                end
                else
                begin
                    out_next.reply_lead = frp_pkg::CH_FOUR;
                    out_next.reply_code = frp_pkg::CODE_LOST;
                    out_next.lost_peer  = 1'b1;
                end
                tn_next         = TN_NONE;
                pv_next         = PV_IDLE;
                wont_next       = 1'b0;
                line_pos_next   = '0;
                line_code_next  = '0;
                first_code_next = '0;
                cont_next       = 1'b0;
                lead_next       = '0;
            end
            else
            begin
                unique case (tn_reg)
                    TN_AFTER:
                    begin
                        // Command byte after IAC.
                        if (item.is_will_wont)
                        begin
                            wont_next = 1'b0;
                            tn_next   = TN_OPTION;
                        end
                        else if (item.is_do_dont)
                        begin
                            wont_next = 1'b1;
                            tn_next   = TN_OPTION;
                        end
                        else
                        begin
                            tn_next = TN_NONE;
                        end
                    end
                    TN_OPTION:
                    begin
                        // Option byte: refuse it.
                        out_next.neg_send   = 1'b1;
                        out_next.neg_verb   = wont_reg;
                        out_next.neg_option = item.data;
                        tn_next             = TN_NONE;
                    end
                    default:
                    begin
                        tn_next = TN_NONE;
                        if (item.is_iac)
                        begin
                            tn_next = TN_AFTER;
                        end
                        else if (item.is_lf)
                        begin
                            if (cont_reg && (line_code_reg != first_code_reg))
                            begin
                                // A continuation line ends; the reply goes on.
                                if (first_code_reg == '0)
                                begin
                                    first_code_next = line_code_reg;
                                end
                            end
                            else
                            begin
                                out_next.reply_done = 1'b1;
                                out_next.reply_lead = lead_reg;
                                out_next.reply_code = line_code_reg;
                                out_next.lost_peer  = (line_code_reg == frp_pkg::CODE_LOST)
                                                   || (first_code_reg == frp_pkg::CODE_LOST);
                                first_code_next = '0;
                                cont_next       = 1'b0;
                                pv_next         = PV_IDLE;
                            end
                            line_pos_next  = '0;
                            line_code_next = '0;
                            lead_next      = '0;
                        end
                        else
                        begin
                            // Ordinary text byte.
                            line_pos_next = pos_inc;
                            if ((pos_inc < 3'd4) && item.is_digit)
                            begin
                                line_code_next = code_times_ten + {6'd0, item.digit_val};
                            end
                            if ((pv_reg == PV_IDLE) && (line_code_next == frp_pkg::CODE_PASV))
                            begin
                                pv_next = PV_SAW;
                            end
                            if ((pos_inc > 3'd4) && (pv_next == PV_SAW) && item.is_digit)
                            begin
                                pv_next = PV_STREAM;
                            end
                            if (pv_next == PV_STREAM)
                            begin
                                if (!item.is_term)
                                begin
                                    out_next.pasv_valid = 1'b1;
                                    out_next.pasv_byte  = item.data;
                                end
                                else
                                begin
                                    out_next.pasv_last = 1'b1;
                                    pv_next            = PV_DONE;
                                end
                            end
                            if ((pos_inc == 3'd4) && item.is_dash)
                            begin
                                if (cont_reg)
                                begin
                                    line_code_next = '0;
                                end
                                cont_next = 1'b1;
                            end
                            if (lead_reg == '0)
                            begin
                                lead_next = item.data;
                            end
                        end
                    end
                endcase
            end
        end
        else
        begin
            out_next = out_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tn_reg         <= TN_NONE;
            pv_reg         <= PV_IDLE;
            wont_reg       <= 1'b0;
            line_pos_reg   <= '0;
            line_code_reg  <= '0;
            first_code_reg <= '0;
            cont_reg       <= 1'b0;
            lead_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            tn_reg         <= tn_next;
            pv_reg         <= pv_next;
            wont_reg       <= wont_next;
            line_pos_reg   <= line_pos_next;
            line_code_reg  <= line_code_next;
            first_code_reg <= first_code_next;
            cont_reg       <= cont_next;
            lead_reg       <= lead_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

endmodule

// ===== hdl/ftp_reply_parser.sv =====
// A request passes through the queue and then the result register, and
// each request ahead of it in the queue delays its result further.
// Throughput: one request per cycle while the result is not stalled.
// The queue holds QueueDepth requests behind the result register, so input
// stall rises only once a stalled result has QueueDepth requests waiting.
// Reset (rst_n low, asynchronous) clears parser state, queue and result.
module ftp_reply_parser
#(
    parameter int QueueDepth = frp_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [7:0] rx_byte,
    input  logic       end_of_stream,
    input  logic       expect_close,
    output logic       result_valid,
    input  logic       result_stall,
    output logic       neg_send,
    output logic       neg_verb,
    output logic [7:0] neg_option,
    output logic       pasv_valid,
    output logic [7:0] pasv_byte,
    output logic       pasv_last,
    output logic       reply_done,
    output logic [7:0] reply_lead,
    output logic [9:0] reply_code,
    output logic       lost_peer
);

    frp_pkg::item_t   classified;
    frp_pkg::item_t   head;
    frp_pkg::result_t result;
    logic             q_full;
    logic             q_not_empty;
    logic             take;

    // Front: classify each byte.
    frp_front u_front
    (
        .rx_byte       (rx_byte),
        .end_of_stream (end_of_stream),
        .expect_close  (expect_close),
        .item          (classified)
    );

    // Queue between classifier and parser.
    frp_queue #(.Depth(QueueDepth)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (item_valid),
        .push_item (classified),
        .full      (q_full),
        .pop       (take),
        .not_empty (q_not_empty),
        .head      (head)
    );

    assign item_stall = q_full;

    // Back: reply parsing and result register.
    frp_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .avail        (q_not_empty),
        .item         (head),
        .take         (take),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assign neg_send   = result.neg_send;
    assign neg_verb   = result.neg_verb;
    assign neg_option = result.neg_option;
    assign pasv_valid = result.pasv_valid;
    assign pasv_byte  = result.pasv_byte;
    assign pasv_last  = result.pasv_last;
    assign reply_done = result.reply_done;
    assign reply_lead = result.reply_lead;
    assign reply_code = result.reply_code;
    assign lost_peer  = result.lost_peer;

endmodule

// ===== hdl/frp_checker.sv =====
module frp_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_stall,
    input logic       result_valid,
    input logic       result_stall,
    input logic       neg_send,
    input logic       pasv_valid,
    input logic [7:0] pasv_byte,
    input logic       pasv_last,
    input logic       reply_done,
    input logic [7:0] reply_lead,
    input logic [9:0] reply_code,
    input logic       lost_peer
);

    // A held result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

    // A request taken while no result is offered comes out through the queue and the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && !result_valid |-> ##2 result_valid)
    else $error("request lost in the pipeline");

    // A refusal and an address byte never share a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(neg_send && pasv_valid))
    else $error("refusal and address byte together");

    // Reply fields are zero unless a reply ends.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !reply_done |-> reply_code == '0 && reply_lead == '0 && !lost_peer)
    else $error("reply fields set without reply end");

    // The terminator is not itself an address byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && pasv_last |-> !pasv_valid && pasv_byte == '0)
    else $error("terminator streamed as address byte");

endmodule

bind ftp_reply_parser frp_checker u_frp_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .neg_send     (neg_send),
    .pasv_valid   (pasv_valid),
    .pasv_byte    (pasv_byte),
    .pasv_last    (pasv_last),
    .reply_done   (reply_done),
    .reply_lead   (reply_lead),
    .reply_code   (reply_code),
    .lost_peer    (lost_peer)
);

// ===== dv/tb_top.sv =====
module tb_top;

    // Phases of the passive address capture and of a telnet command.
    typedef enum logic [1:0] {ADDR_IDLE, ADDR_ARMED, ADDR_STREAM, ADDR_DONE} addr_phase_t;
    typedef enum logic [1:0] {TN_QUIET, TN_AFTER_IAC, TN_OPTION} tn_phase_t;

    localparam int QUIET_LIMIT = 1000;
    localparam int ITEM_TARGET = 540;

    // Predicts the parser output for every accepted request and checks the
    // results against it in order.
    class reply_scoreboard_t;
        logic [2:0]       col;
        logic [9:0]       code_acc;
        logic [9:0]       opening_code;
        logic             multi_line;
        logic [7:0]       lead_char;
        addr_phase_t      addr_phase;
        tn_phase_t        tn_phase;
        logic             refusal_wont;
        frp_pkg::result_t outputs_due[$];
        int               errors;

        function new();
            errors = 0;
            clear_all();
        endfunction

        function void clear_line();
            col = '0;
            code_acc = '0;
            lead_char = '0;
        endfunction

        function void clear_reply();
            clear_line();
            opening_code = '0;
            multi_line = 1'b0;
            addr_phase = ADDR_IDLE;
        endfunction

        function void clear_all();
            clear_reply();
            tn_phase = TN_QUIET;
            refusal_wont = 1'b0;
        endfunction

        function int pending();
            return outputs_due.size();
        endfunction

        // Works out the result of one received byte and updates the parser state.
        function frp_pkg::result_t parse_byte(logic [7:0] b, logic eos, logic closing);
            frp_pkg::result_t r;
            logic             is_digit;
            r = '0;
            is_digit = (b >= frp_pkg::CH_ZERO) && (b <= frp_pkg::CH_NINE);
            if (eos)
            begin
                r.reply_done = 1'b1;
                if (closing)
                begin
                    r.reply_lead = frp_pkg::CH_ZERO;
                    r.reply_code = frp_pkg::CODE_BYE;
                end
                else
                begin
                    r.reply_lead = frp_pkg::CH_FOUR;
                    r.reply_code = frp_pkg::CODE_LOST;
                    r.lost_peer = 1'b1;
                end
                clear_all();
            end
            else if (tn_phase == TN_AFTER_IAC)
            begin
                // WILL and WONT are refused with DONT, DO and DONT with WONT.
                if (b == frp_pkg::TN_WILL || b == frp_pkg::TN_WONT)
                begin
                    refusal_wont = 1'b0;
                    tn_phase = TN_OPTION;
                end
                else if (b == frp_pkg::TN_DO || b == frp_pkg::TN_DONT)
                begin
                    refusal_wont = 1'b1;
                    tn_phase = TN_OPTION;
                end
                else
                    tn_phase = TN_QUIET;
            end
            else if (tn_phase == TN_OPTION)
            begin
                r.neg_send = 1'b1;
                r.neg_verb = refusal_wont;
                r.neg_option = b;
                tn_phase = TN_QUIET;
            end
            else if (b == frp_pkg::TN_IAC)
                tn_phase = TN_AFTER_IAC;
            else if (b == frp_pkg::CH_LF)
            begin
                // A continuation line whose code differs keeps the reply open.
                if (multi_line && code_acc != opening_code)
                begin
                    if (opening_code == '0)
                        opening_code = code_acc;
                    clear_line();
                end
                else
                begin
                    r.reply_done = 1'b1;
                    r.reply_lead = lead_char;
                    r.reply_code = code_acc;
                    r.lost_peer = (code_acc == frp_pkg::CODE_LOST)
                               || (opening_code == frp_pkg::CODE_LOST);
                    clear_reply();
                end
            end
            else
            begin
                col = (col < 3'd5) ? col + 3'd1 : 3'd5;
                if (col < 3'd4 && is_digit)
                    code_acc = 10'(int'(code_acc) * 10 + int'(b - frp_pkg::CH_ZERO));
                if (addr_phase == ADDR_IDLE && code_acc == frp_pkg::CODE_PASV)
                    addr_phase = ADDR_ARMED;
                if (col > 3'd4 && addr_phase == ADDR_ARMED && is_digit)
                    addr_phase = ADDR_STREAM;
                if (addr_phase == ADDR_STREAM)
                begin
                    if (b != frp_pkg::CH_CR && b != frp_pkg::CH_RPAR)
                    begin
                        r.pasv_valid = 1'b1;
                        r.pasv_byte = b;
                    end
                    else
                    begin
                        r.pasv_last = 1'b1;
                        addr_phase = ADDR_DONE;
                    end
                end
                // A dash at position four opens or renews a continuation.
                if (col == 3'd4 && b == frp_pkg::CH_DASH)
                begin
                    if (multi_line)
                        code_acc = '0;
                    multi_line = 1'b1;
                end
                if (lead_char == '0)
                    lead_char = b;
            end
            return r;
        endfunction

        function void note_request(logic [7:0] b, logic eos, logic closing);
            outputs_due.push_back(parse_byte(b, eos, closing));
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        task compare_field(string name, logic [9:0] got, logic [9:0] want);
            if (got !== want)
                report($sformatf("%s: got %0h, expected %0h", name, got, want));
        endtask

        task check_result(frp_pkg::result_t got);
            frp_pkg::result_t want;
            if (outputs_due.size() == 0)
            begin
                report("result arrived with no request waiting");
                return;
            end
            want = outputs_due.pop_front();
            compare_field("neg_send", 10'(got.neg_send), 10'(want.neg_send));
            compare_field("neg_verb", 10'(got.neg_verb), 10'(want.neg_verb));
            compare_field("neg_option", 10'(got.neg_option), 10'(want.neg_option));
            compare_field("pasv_valid", 10'(got.pasv_valid), 10'(want.pasv_valid));
            compare_field("pasv_byte", 10'(got.pasv_byte), 10'(want.pasv_byte));
            compare_field("pasv_last", 10'(got.pasv_last), 10'(want.pasv_last));
            compare_field("reply_done", 10'(got.reply_done), 10'(want.reply_done));
            compare_field("reply_lead", 10'(got.reply_lead), 10'(want.reply_lead));
            compare_field("reply_code", got.reply_code, want.reply_code);
            compare_field("lost_peer", 10'(got.lost_peer), 10'(want.lost_peer));
        endtask
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             item_valid = 1'b0;
    logic             item_stall;
    logic [7:0]       rx_byte = '0;
    logic             end_of_stream = 1'b0;
    logic             expect_close = 1'b0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    logic             neg_send;
    logic             neg_verb;
    logic [7:0]       neg_option;
    logic             pasv_valid;
    logic [7:0]       pasv_byte;
    logic             pasv_last;
    logic             reply_done;
    logic [7:0]       reply_lead;
    logic [9:0]       reply_code;
    logic             lost_peer;
    frp_pkg::result_t observed;

    bit                idling_on = 1'b1;
    int                items_sent = 0;
    reply_scoreboard_t replies;

    ftp_reply_parser dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .rx_byte(rx_byte),
        .end_of_stream(end_of_stream),
        .expect_close(expect_close),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .neg_send(neg_send),
        .neg_verb(neg_verb),
        .neg_option(neg_option),
        .pasv_valid(pasv_valid),
        .pasv_byte(pasv_byte),
        .pasv_last(pasv_last),
        .reply_done(reply_done),
        .reply_lead(reply_lead),
        .reply_code(reply_code),
        .lost_peer(lost_peer)
    );

    assign observed = {neg_send, neg_verb, neg_option, pasv_valid, pasv_byte, pasv_last,
                       reply_done, reply_lead, reply_code, lost_peer};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The result side stalls at random unless idling is switched off.
    always @(posedge clk)
    begin
        result_stall <= idling_on && ($urandom_range(99) < 8);
    end

    // Every accepted result is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            replies.check_result(observed);
    end

    function automatic logic coin();
        return 1'($urandom_range(1));
    endfunction

    function automatic logic [7:0] text_char();
        if ($urandom_range(15) == 0)
            return 8'($urandom_range(255));
        return 8'($urandom_range(8'h7E, 8'h20));
    endfunction

    // Presents one request, holds it until accepted and records the prediction.
    task automatic send_item(input logic [7:0] b, input logic eos, input logic closing);
        while (idling_on && $urandom_range(99) < 8)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        rx_byte <= b;
        end_of_stream <= eos;
        expect_close <= closing;
        do
            @(posedge clk);
        while (item_stall);
        replies.note_request(b, eos, closing);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        foreach (s[i])
            send_item(s[i], 1'b0, 1'b0);
    endtask

    // The sender holds off until the parser has delivered every result.
    task automatic wait_for_results();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (replies.pending() != 0);
    endtask

    // An IAC sequence, sometimes cut short by a close.
    task automatic send_telnet();
        logic [7:0] verb;
        case ($urandom_range(4))
            0: verb = frp_pkg::TN_WILL;
            1: verb = frp_pkg::TN_WONT;
            2: verb = frp_pkg::TN_DO;
            3: verb = frp_pkg::TN_DONT;
            default: verb = 8'($urandom_range(255));
        endcase
        send_item(frp_pkg::TN_IAC, 1'b0, coin());
        if ($urandom_range(9) == 0)
            send_item(verb, 1'b1, coin());
        else
        begin
            send_item(verb, 1'b0, coin());
            if (verb >= frp_pkg::TN_WILL && verb <= frp_pkg::TN_DONT)
                send_item(8'($urandom_range(255)), 1'b0, coin());
        end
    endtask

    // A reply byte, with telnet commands and the odd close mixed in.
    task automatic send_text_byte(input logic [7:0] b);
        if ($urandom_range(24) == 0)
            send_telnet();
        if ($urandom_range(199) == 0)
            send_item(8'($urandom_range(255)), 1'b1, coin());
        send_item(b, 1'b0, coin());
    endtask

    task automatic send_line(input bit with_code, input int unsigned code,
                             input logic [7:0] sep);
        string digits;
        if ($urandom_range(19) == 0)
            send_text_byte(8'h00);
        if (with_code)
        begin
            digits = $sformatf("%0d", code);
            foreach (digits[i])
                send_text_byte(digits[i]);
            send_text_byte(sep);
        end
        repeat ($urandom_range(4))
            send_text_byte(text_char());
        // Passive replies carry the address in parentheses.
        if (code == frp_pkg::CODE_PASV || $urandom_range(9) == 0)
        begin
            send_text_byte("(");
            repeat ($urandom_range(12, 1))
                send_text_byte(($urandom_range(3) == 0)
                               ? "," : 8'(frp_pkg::CH_ZERO + $urandom_range(9)));
            case ($urandom_range(3))
                0: ; // Left open, so the address runs on into the next line.
                1: send_text_byte(frp_pkg::CH_CR);
                default: send_text_byte(frp_pkg::CH_RPAR);
            endcase
        end
        if (coin())
            send_text_byte(frp_pkg::CH_CR);
        send_text_byte(frp_pkg::CH_LF);
    endtask

    // A well-formed reply of one or more lines with random content.
    task automatic send_random_reply();
        int unsigned code;
        int unsigned lines;
        int unsigned k;
        case ($urandom_range(9))
            0, 1, 2: code = frp_pkg::CODE_PASV;
            3:       code = frp_pkg::CODE_LOST;
            4:       code = frp_pkg::CODE_BYE;
            default: code = $urandom_range(599, 100);
        endcase
        lines = ($urandom_range(3) == 0) ? $urandom_range(4, 2) : 1;
        for (k = 0; k < lines; k++)
        begin
            if (k == lines - 1)
                send_line(1'b1, code, " ");
            else if (k == 0)
                send_line(1'b1, code, frp_pkg::CH_DASH);
            else
            begin
                case ($urandom_range(2))
                    0: send_line(1'b0, code, " ");
                    1: send_line(1'b1, $urandom_range(999, 100), frp_pkg::CH_DASH);
                    default: send_line(1'b1, code, frp_pkg::CH_DASH);
                endcase
            end
        end
    endtask

    // Ends the run when no request moves on either side for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        replies = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Close with a byte that must be ignored, then all four refusals
        // with the option extremes, an escaped IAC and a close inside IAC.
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(frp_pkg::TN_IAC, 1'b0, 1'b0);
        send_item(frp_pkg::TN_WILL, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(frp_pkg::TN_IAC, 1'b0, 1'b1);
        send_item(frp_pkg::TN_WONT, 1'b0, 1'b1);
        send_item(8'h80, 1'b0, 1'b1);
        send_item(frp_pkg::TN_IAC, 1'b0, 1'b0);
        send_item(frp_pkg::TN_DO, 1'b0, 1'b0);
        send_item(8'h7F, 1'b0, 1'b0);
        send_item(frp_pkg::TN_IAC, 1'b0, 1'b0);
        send_item(frp_pkg::TN_DONT, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(frp_pkg::TN_IAC, 1'b0, 1'b0);
        send_item(frp_pkg::TN_IAC, 1'b0, 1'b0);
        send_item(frp_pkg::TN_IAC, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);

        // A passive reply over three lines: the address crosses a line feed,
        // a zero byte leads a line, a second dash clears its code.
        send_text("227-1\n");
        send_item(8'h00, 1'b0, 1'b0);
        send_text("12-)\n");
        send_text("227\n");
        wait_for_results();

        // Random replies, noise and closes; idling pauses for a long stretch.
        while (items_sent < ITEM_TARGET)
        begin
            idling_on = !(items_sent >= 220 && items_sent < 360);
            if ($urandom_range(6) == 0)
            begin
                repeat ($urandom_range(8, 1))
                    send_item(8'($urandom_range(255)), 1'b0, coin());
            end
            else
                send_random_reply();
            if ($urandom_range(11) == 0)
                send_item(8'($urandom_range(255)), 1'b1, coin());
            if ($urandom_range(29) == 0)
                wait_for_results();
        end

        item_valid <= 1'b0;
        while (replies.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (replies.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
